FILE: hw/rtl/pcrq_pkg.sv
// Package for the per-channel requantizer: item structs, register indexes,
// command/status structs between controller and datapath, and sizing constants.
// No dependencies.
package pcrq_pkg;

	// Sizing
	localparam int unsigned MAX_CHANNELS = 1024;
	localparam int unsigned ADDR_W       = $clog2(MAX_CHANNELS);
	localparam int unsigned SPATIAL_MAX  = 1048576;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 24;
	localparam int unsigned COEF_W       = 56;   // {scale[23:0], bias[31:0]}
	localparam int unsigned MAG_CLAMP    = 1024; // clamp on rounded magnitude

	// Item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_ZERO      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_SCALE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_INV_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_ZERO      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_COUNT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT        = 3'd6;

	// Layout codes
	localparam logic LAYOUT_CH_LAST = 1'b0;
	localparam logic LAYOUT_PLANAR  = 1'b1;

	typedef struct packed {
		logic               op;
		logic [9:0]         load_channel;
		logic signed [23:0] load_scale;
		logic signed [31:0] load_bias;
		logic [7:0]         sample;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic [9:0] out_channel;
		logic       end_of_tensor;
	} out_item_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic accept;   // input item taken this cycle
		logic calc_d;   // (x - src_zero) * src_scale
		logic calc_p;   // d * channel scale
		logic calc_v;   // add bias, take magnitude
		logic calc_h;   // high partial product with dst_inv_scale
		logic calc_l;   // low partial product with dst_inv_scale
		logic finish;   // round, saturate, load output register
	} dp_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic in_is_data;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hw/rtl/per_channel_requantize_scale.sv
// Per-channel affine requantizer of uint8 tensor samples.
// Sequence: after accept, a data item steps through MUL1, MUL2, ADD, MULH, MULL
// and RND, where it waits for a free output register; no new item is taken
// until it is done. A coefficient load gives no result.
// Reset: config registers to defaults, counters to zero; coefficient table is
// not cleared and must be loaded before use. No clearing pass.
module per_channel_requantize_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pcrq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcrq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  pcrq_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output pcrq_pkg::out_item_t             out_item
);

	pcrq_pkg::dp_cmd_t    cmd;
	pcrq_pkg::dp_status_t status;

	pcrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pcrq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.status    (status)
	);

	// Result only lands when the output register can take it
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || !out_stall))
		else $error("result loaded over an untaken output item");

	// A data item starts the arithmetic sequence the next cycle
	a_data_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && in_item.op == pcrq_pkg::OP_DATA) |=> cmd.calc_d)
		else $error("data item accepted without starting computation");

	// A finished result is presented next cycle
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished result not presented");

	// No new item is taken while the arithmetic is in progress
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.calc_d || cmd.calc_p || cmd.calc_v || cmd.calc_h || cmd.calc_l) |-> in_stall)
		else $error("input open during computation");

endmodule

FILE: hw/rtl/pcrq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/pcrq_ctrl.sv
// Sequencing controller for the requantizer: one-hot FSM stepping the datapath.
// Depends on pcrq_pkg.
module pcrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pcrq_pkg::dp_status_t status,
	output pcrq_pkg::dp_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL1 = 7'b0000010,
		ST_MUL2 = 7'b0000100,
		ST_ADD  = 7'b0001000,
		ST_MULH = 7'b0010000,
		ST_MULL = 7'b0100000,
		ST_RND  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Input is taken only between items
	assign in_stall = (state_q != ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.in_is_data == pcrq_pkg::OP_DATA) begin
						state_d = ST_MUL1;
					end
				end
			end
			ST_MUL1: begin
				cmd.calc_d = 1'b1;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.calc_p = 1'b1;
				state_d    = ST_ADD;
			end
			ST_ADD: begin
				cmd.calc_v = 1'b1;
				state_d    = ST_MULH;
			end
			ST_MULH: begin
				cmd.calc_h = 1'b1;
				state_d    = ST_MULL;
			end
			ST_MULL: begin
				cmd.calc_l = 1'b1;
				state_d    = ST_RND;
			end
			ST_RND: begin
				// wait here until the output register can take the result
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/pcrq_dp.sv
// Datapath of the requantizer: config registers, tensor counters, coefficient
// table, multi-step fixed-point arithmetic and the output register.
// Depends on pcrq_pkg and pcrq_ram.
module pcrq_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pcrq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcrq_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  pcrq_pkg::in_item_t                   in_item,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output pcrq_pkg::out_item_t                  out_item,
	input  pcrq_pkg::dp_cmd_t                    cmd,
	output pcrq_pkg::dp_status_t                 status
);

	// Configuration registers
	logic [7:0]  src_zero_q;
	logic [23:0] src_scale_q;
	logic [23:0] dst_inv_scale_q;
	logic [7:0]  dst_zero_q;
	logic [10:0] channel_count_q;
	logic [20:0] spatial_count_q;
	logic        layout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_zero_q      <= 8'd0;
			src_scale_q     <= 24'd65536;
			dst_inv_scale_q <= 24'd65536;
			dst_zero_q      <= 8'd0;
			channel_count_q <= 11'd1;
			spatial_count_q <= 21'd1;
			layout_q        <= pcrq_pkg::LAYOUT_CH_LAST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pcrq_pkg::CFG_SRC_ZERO:      src_zero_q      <= cfg_data[7:0];
				pcrq_pkg::CFG_SRC_SCALE:     src_scale_q     <= cfg_data[23:0];
				pcrq_pkg::CFG_DST_INV_SCALE: dst_inv_scale_q <= cfg_data[23:0];
				pcrq_pkg::CFG_DST_ZERO:      dst_zero_q      <= cfg_data[7:0];
				pcrq_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[10:0];
				pcrq_pkg::CFG_SPATIAL_COUNT: spatial_count_q <= cfg_data[20:0];
				pcrq_pkg::CFG_LAYOUT:        layout_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective counts, clamped to their legal ranges
	logic [10:0] ch_n;
	logic [20:0] sp_n;

	always_comb begin
		if (channel_count_q == 11'd0) begin
			ch_n = 11'd1;
		end else if (channel_count_q > 11'(pcrq_pkg::MAX_CHANNELS)) begin
			ch_n = 11'(pcrq_pkg::MAX_CHANNELS);
		end else begin
			ch_n = channel_count_q;
		end
		if (spatial_count_q == 21'd0) begin
			sp_n = 21'd1;
		end else if (spatial_count_q > 21'(pcrq_pkg::SPATIAL_MAX)) begin
			sp_n = 21'(pcrq_pkg::SPATIAL_MAX);
		end else begin
			sp_n = spatial_count_q;
		end
	end

	// Tensor position counters
	logic [9:0]  chan_cnt_q;
	logic [19:0] pos_cnt_q;
	logic        last_c, last_s;
	logic        data_acc, load_acc;

	assign data_acc = cmd.accept && (in_item.op == pcrq_pkg::OP_DATA);
	assign load_acc = cmd.accept && (in_item.op == pcrq_pkg::OP_LOAD);
	assign last_c   = ({1'b0, chan_cnt_q} + 11'd1) >= ch_n;
	assign last_s   = ({1'b0, pos_cnt_q} + 21'd1) >= sp_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= '0;
			pos_cnt_q  <= '0;
		end else if (data_acc) begin
			if (layout_q == pcrq_pkg::LAYOUT_CH_LAST) begin
				if (last_c) begin
					chan_cnt_q <= '0;
					pos_cnt_q  <= last_s ? '0 : pos_cnt_q + 20'd1;
				end else begin
					chan_cnt_q <= chan_cnt_q + 10'd1;
				end
			end else begin
				if (last_s) begin
					pos_cnt_q  <= '0;
					chan_cnt_q <= last_c ? '0 : chan_cnt_q + 10'd1;
				end else begin
					pos_cnt_q <= pos_cnt_q + 20'd1;
				end
			end
		end
	end

	// Per-item metadata captured at accept
	logic [7:0] sample_q;
	logic [9:0] chan_q;
	logic       eot_q;

	always_ff @(posedge clk) begin
		if (data_acc) begin
			sample_q <= in_item.sample;
			chan_q   <= chan_cnt_q;
			eot_q    <= last_c && last_s;
		end
	end

	// Coefficient table: loads write, data items read the current channel
	logic                           tbl_wr;
	logic [pcrq_pkg::COEF_W-1:0]    coef;
	logic [pcrq_pkg::ADDR_W-1:0]    rd_addr;

	assign tbl_wr  = load_acc && (32'(in_item.load_channel) < pcrq_pkg::MAX_CHANNELS);
	assign rd_addr = (32'(chan_cnt_q) >= pcrq_pkg::MAX_CHANNELS)
		? pcrq_pkg::ADDR_W'(pcrq_pkg::MAX_CHANNELS - 1)
		: chan_cnt_q[pcrq_pkg::ADDR_W-1:0];

	pcrq_ram #(
		.WIDTH(pcrq_pkg::COEF_W),
		.DEPTH(pcrq_pkg::MAX_CHANNELS)
	) u_coef_ram (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (in_item.load_channel[pcrq_pkg::ADDR_W-1:0]),
		.wr_data ({in_item.load_scale, in_item.load_bias}),
		.rd_en   (data_acc),
		.rd_addr (rd_addr),
		.rd_data (coef)
	);

	logic signed [23:0] chan_scale;
	logic signed [31:0] chan_bias;

	assign chan_scale = $signed(coef[55:32]);
	assign chan_bias  = $signed(coef[31:0]);

	// Step 1: dequantize, Q.16
	logic signed [8:0]  diff;
	logic signed [33:0] d_full;
	logic signed [32:0] d_q;

	assign diff   = $signed({1'b0, sample_q}) - $signed({1'b0, src_zero_q});
	assign d_full = diff * $signed({1'b0, src_scale_q});

	// Step 2: channel scale, Q.32
	logic signed [56:0] p_full;
	logic signed [56:0] prod_q;

	assign p_full = d_q * chan_scale;

	// Step 3: bias add and magnitude
	logic signed [57:0] v_sum;
	logic signed [57:0] v_neg;
	logic [56:0]        mag_q;
	logic               neg_q;

	assign v_sum = {prod_q[56], prod_q} + {{10{chan_bias[31]}}, chan_bias, 16'd0};
	assign v_neg = -v_sum;

	// Steps 4 and 5: partial products with dst_inv_scale
	logic [56:0] hi_full;
	logic [47:0] lo_full;
	logic [56:0] hi_q;
	logic [47:0] lo_q;

	assign hi_full = mag_q[56:24] * dst_inv_scale_q;
	assign lo_full = mag_q[23:0] * dst_inv_scale_q;

	always_ff @(posedge clk) begin
		if (cmd.calc_d) begin
			d_q <= d_full[32:0];
		end
		if (cmd.calc_p) begin
			prod_q <= p_full;
		end
		if (cmd.calc_v) begin
			neg_q <= v_sum[57];
			mag_q <= v_sum[57] ? v_neg[56:0] : v_sum[56:0];
		end
		if (cmd.calc_h) begin
			hi_q <= hi_full;
		end
		if (cmd.calc_l) begin
			lo_q <= lo_full;
		end
	end

	// Step 6: combine, round half to even, clamp, offset, saturate
	logic [57:0] t_sum;
	logic [33:0] ip;
	logic [47:0] frac;
	logic        rnd_up;
	logic [34:0] ip_r;
	logic [10:0] ip_c;
	logic [12:0] r_val;
	logic [7:0]  res;

	always_comb begin
		t_sum  = {1'b0, hi_q} + 58'(lo_q[47:24]);
		ip     = t_sum[57:24];
		frac   = {t_sum[23:0], lo_q[23:0]};
		rnd_up = frac[47] && ((|frac[46:0]) || ip[0]);
		ip_r   = {1'b0, ip} + 35'(rnd_up);
		ip_c   = (ip_r > 35'(pcrq_pkg::MAG_CLAMP)) ? 11'(pcrq_pkg::MAG_CLAMP) : ip_r[10:0];
		r_val  = neg_q ? (13'(dst_zero_q) - 13'(ip_c)) : (13'(dst_zero_q) + 13'(ip_c));
		if (r_val[12]) begin
			res = 8'd0;
		end else if (r_val[11:0] > 12'd255) begin
			res = 8'd255;
		end else begin
			res = r_val[7:0];
		end
	end

	// Output register
	logic                out_valid_q;
	pcrq_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.out_value     <= res;
			out_q.out_channel   <= chan_q;
			out_q.end_of_tensor <= eot_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_item          = out_q;
	assign status.in_is_data = in_item.op;
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule
